@@ sv/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// LED color cross-fade package
// Shared widths, command codes, defaults and the cell control bundle.
// ----------------------------------------------------------------------------
package lcc_pkg;

   // Field widths.
   localparam int CMD_W   = 2;
   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int CHAN_N  = 3;
   localparam int INDEX_W = 3;
   localparam int STEP_W  = 5;

   // Blend arithmetic: a channel numerator stays below 2^NUM_W for any step
   // count up to 30, and the reciprocal shift makes the quotient exact.
   localparam int NUM_W    = CHAN_W + STEP_W;
   localparam int RECIP_SH = NUM_W + STEP_W;
   localparam int PROD_W   = 32;

   // Parameter defaults.
   localparam int LED_COUNT_DEF  = 8;
   localparam int FADE_STEPS_DEF = 21;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FADE = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } state_type;

   // Control bundle broadcast from the sequencer to every cell.
   typedef struct packed {
      logic set_target;
      logic copy_start;
      logic mul_en;
      logic div_en;
      logic fin_en;
      logic shift_en;
   } cell_ctrl_type;

endpackage

@@ sv/lcc_cell.sv @@
// ----------------------------------------------------------------------------
// LED color cross-fade cell
// Holds one LED's target, start and shown colors, blends them in three
// registered stages and passes finished words toward the head of the chain.
// ----------------------------------------------------------------------------
module lcc_cell
   import lcc_pkg::*;
#(
   parameter int FADE_STEPS = FADE_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [COLOR_W-1:0]  set_color,
   input  logic [STEP_W-1:0]   step,
   input  logic [COLOR_W-1:0]  next_word,
   output logic [COLOR_W-1:0]  out_word
);

   // Reciprocal of the step count, rounded up, for an exact floor division.
   localparam int RECIP = ((1 << RECIP_SH) + FADE_STEPS - 1) / FADE_STEPS;

   logic [COLOR_W-1:0] target_ff, target_in;
   logic [COLOR_W-1:0] start_ff, start_in;
   logic [COLOR_W-1:0] shown_ff, shown_in;
   logic [COLOR_W-1:0] out_ff, out_in;
   logic [NUM_W-1:0]   ps_ff [CHAN_N];
   logic [NUM_W-1:0]   pt_ff [CHAN_N];
   logic [PROD_W-1:0]  prod_ff [CHAN_N];
   logic [COLOR_W-1:0] blended;
   logic [STEP_W-1:0]  rest;

   assign rest = STEP_W'(FADE_STEPS) - step;

   // Color state: targets load on a set command, starts copy the shown colors.
   always_comb begin
      target_in = ctrl.set_target ? set_color : target_ff;
      start_in  = ctrl.copy_start ? shown_ff : start_ff;
      shown_in  = ctrl.fin_en ? blended : shown_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         start_ff  <= '0;
         shown_ff  <= '0;
      end else begin
         target_ff <= target_in;
         start_ff  <= start_in;
         shown_ff  <= shown_in;
      end
   end

   // Blend pipeline: two products, then the sum times the reciprocal.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHAN_N; c++) begin
         if (ctrl.mul_en) begin
            ps_ff[c] <= NUM_W'(start_ff[c*CHAN_W +: CHAN_W]) * NUM_W'(rest);
            pt_ff[c] <= NUM_W'(target_ff[c*CHAN_W +: CHAN_W]) * NUM_W'(step);
         end
         if (ctrl.div_en) begin
            prod_ff[c] <= PROD_W'(ps_ff[c] + pt_ff[c]) * PROD_W'(RECIP);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         blended[c*CHAN_W +: CHAN_W] = prod_ff[c][RECIP_SH +: CHAN_W];
      end
   end

   // Output word: loaded with the new shown color, then shifted to the head.
   always_comb begin
      out_in = out_ff;
      if (ctrl.fin_en) begin
         out_in = blended;
      end else if (ctrl.shift_en) begin
         out_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_word = out_ff;

endmodule

@@ sv/led_color_crossfade_top.sv @@
// ----------------------------------------------------------------------------
// LED color cross-fade top level
// Sequencer over a chain of per-LED cells that blend and stream color words.
// ----------------------------------------------------------------------------
// Set-color and fade requests are taken in the idle state. A frame tick that
// renders passes through the multiply, divide and finish states, blending in
// parallel in every LED cell, then streams one word per LED out of the head
// of the cell chain, one word per cycle while the result side does not stall.
// A tick after the fade has finished yields no words. A new request is
// taken only once the last word of the frame has been delivered.
module led_color_crossfade_top
   import lcc_pkg::*;
#(
   parameter int LED_COUNT  = LED_COUNT_DEF,
   parameter int FADE_STEPS = FADE_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] color
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] led_color, [26:24] led_index
   output logic        rsp_tlast    // last_led
);

   localparam int CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                pending_ff, pending_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   cell_ctrl_type       ctrl;
   logic [COLOR_W-1:0]  words [LED_COUNT+1];
   logic                req_fire;
   logic                rsp_fire;
   logic                last_word;
   logic [STEP_W-1:0]   step_eff;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign last_word = (cnt_ff == CNT_W'(LED_COUNT - 1));
   assign step_eff  = pending_ff ? '0 : step_ff;

   // Sequencer state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= STEP_W'(FADE_STEPS);
         pending_ff <= 1'b0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         pending_ff <= pending_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
      end
   end

   // Next state and cell controls.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      pending_in = pending_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               unique case (req_tuser)
                  CMD_SET: begin
                     ctrl.set_target = 1'b1;
                  end
                  CMD_FADE: begin
                     pending_in = 1'b1;
                  end
                  CMD_TICK: begin
                     ctrl.copy_start = pending_ff;
                     pending_in      = 1'b0;
                     step_in         = step_eff;
                     if (step_eff <= STEP_W'(FADE_STEPS)) begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_en = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            ctrl.fin_en = 1'b1;
            cnt_in      = '0;
            idx_in      = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_fire) begin
               ctrl.shift_en = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               idx_in        = idx_ff + 1'b1;
               if (last_word) begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Chain of LED cells; words move toward cell 0, which drives the output.
   assign words[LED_COUNT] = '0;

   for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
      lcc_cell #(
         .FADE_STEPS (FADE_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .set_color (req_tdata),
         .step      (step_ff),
         .next_word (words[i+1]),
         .out_word  (words[i])
      );
   end

   // Result word.
   assign rsp_tdata = {5'b0, idx_ff, words[0]};
   assign rsp_tlast = last_word;

endmodule
